// ----- design/page_frame_run_allocator_macros.svh -----
// Assertion helpers for the page-frame run allocator.
`ifndef PAGE_FRAME_RUN_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pfra_pkg.sv -----
`default_nettype none

package pfra_pkg;

  typedef enum logic [1:0] {
    OP_MARK    = 2'd0,
    OP_REBUILD = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_FREE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NONE_FREE    = 3'd1,
    ST_UNUSED_TYPE  = 3'd2,
    ST_BAD_ADDR     = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_ZERO_REFS    = 3'd5,
    ST_EMPTY_RANGE  = 3'd6
  } status_e;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 40;

  // One page descriptor.
  typedef struct packed {
    logic [3:0]  ptype;
    logic [15:0] flags;
    logic [15:0] refs;
  } desc_t;

  // Per-field write enables of the run link store.
  typedef struct packed {
    logic len;
    logic prv;
    logic nxt;
  } link_we_t;

endpackage

`default_nettype wire

// ----- design/pfra_desc_mem.sv -----
`default_nettype none

module pfra_desc_mem
  import pfra_pkg::*;
#(
  parameter int unsigned Depth    = 1024,
  parameter int unsigned AddrBits = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire desc_t               wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output desc_t                    rdata_o
);

  desc_t mem_q [Depth];
  desc_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/pfra_link_mem.sv -----
`default_nettype none

module pfra_link_mem
  import pfra_pkg::*;
#(
  parameter int unsigned Depth    = 1024,
  parameter int unsigned IdxBits  = 11,
  parameter int unsigned AddrBits = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire link_we_t            we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [IdxBits-1:0]  wlen_i,
  input  wire logic [IdxBits-1:0]  wprv_i,
  input  wire logic [IdxBits-1:0]  wnxt_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [IdxBits-1:0]  rlen_o,
  output logic      [IdxBits-1:0]  rprv_o,
  output logic      [IdxBits-1:0]  rnxt_o
);

  logic [IdxBits-1:0] len_q [Depth];
  logic [IdxBits-1:0] prv_q [Depth];
  logic [IdxBits-1:0] nxt_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.len) begin
      len_q[waddr_i] <= wlen_i;
    end
    if (we_i.prv) begin
      prv_q[waddr_i] <= wprv_i;
    end
    if (we_i.nxt) begin
      nxt_q[waddr_i] <= wnxt_i;
    end
    if (re_i) begin
      rlen_o <= len_q[raddr_i];
      rprv_o <= prv_q[raddr_i];
      rnxt_o <= nxt_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/page_frame_run_allocator.sv -----
// Page-frame run allocator. Keeps a descriptor (type, flags, reference count)
// per page plus boundary-tag run lengths and a doubly linked list of free run
// heads, all in two single-port-read synchronous memories. Each item carries an
// operation in tuser: mark stamps a byte range of pages, rebuild rescans the
// table into free runs (highest run ends at the list head), alloc hands out the
// last page of the head run, free drops a reference and merges a released page
// with its free neighbors. Every item gives exactly one result item. Items are
// handled one at a time by a read-modify-write sequencer with one memory access
// per port per cycle. Posting stalls while the previous result still waits. The
// result register lets a new item be taken while the previous result still
// waits. After reset the block sweeps both memories to their cleared state,
// one entry per cycle, before it accepts its first item.
`default_nettype none

module page_frame_run_allocator
  import pfra_pkg::*;
#(
  parameter int unsigned PAGES      = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // address[31:0], end_address[63:32], type_code[67:64], flag_bits[83:68],
  // initial_refs[99:84], zero fill[103:100]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // operation[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // status[2:0], page_address[34:3], released[35], zero fill[39:36]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(PAGES + 1);
  localparam int unsigned AW = $clog2(PAGES);
  localparam logic [IW-1:0] Nil     = IW'(PAGES);
  localparam logic [IW-1:0] LastIdx = IW'(PAGES - 1);
  localparam logic [AW-1:0] LastAdr = AW'(PAGES - 1);
  localparam logic [IW:0]   PagesX  = (IW+1)'(PAGES);
  localparam logic [31:0]   PagesW  = 32'(PAGES);
  localparam logic [31:0]   OffMask = 32'((1 << PAGE_SHIFT) - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_MK0, S_MKW,
    S_RB_RD, S_RB_CHK, S_RB_E1, S_RB_E2, S_RB_E3,
    S_AL0, S_AL1, S_AL2, S_AL3,
    S_FR0, S_FR1, S_FR2, S_FR3, S_FR4,
    S_FA1, S_FA2, S_FB1, S_FB2, S_FB3, S_FB4,
    S_FC1, S_FC2, S_FD1, S_FD2, S_FD3, S_FD4,
    S_DONE
  } state_e;

  function automatic logic [IW-1:0] sat_len(input logic [IW:0] v);
    return (v > PagesX) ? Nil : v[IW-1:0];
  endfunction

  // Registers
  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  op_e           op_q, op_d;
  logic [31:0]   a_q, a_d, e_q, e_d;
  logic [3:0]    type_q, type_d;
  logic [15:0]   flags_q, flags_d, refs_q, refs_d;
  logic [IW-1:0] idx_q, idx_d, i_q, i_d, mlast_q, mlast_d, start_q, start_d;
  logic [IW-1:0] head_q, head_d, lenf_q, lenf_d, lenh_q, lenh_d;
  logic [IW-1:0] nxt_q, nxt_d, prv_q, prv_d, cnt_q, cnt_d;
  logic [IW:0]   ext_q, ext_d;
  logic          in_run_q, in_run_d, has_foot_q, has_foot_d, has_head_q, has_head_d;
  status_e       status_q, status_d;
  logic [31:0]   addr_q, addr_d;
  logic          rel_q, rel_d;
  logic          m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  // Memory ports
  logic          d_we, d_re;
  logic [AW-1:0] d_waddr, d_raddr;
  desc_t         d_wdata, d_rdata;
  link_we_t      l_we;
  logic          l_re;
  logic [AW-1:0] l_waddr, l_raddr;
  logic [IW-1:0] l_wlen, l_wprv, l_wnxt, l_rlen, l_rprv, l_rnxt;

  pfra_desc_mem #(.Depth(PAGES)) u_desc_mem (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  pfra_link_mem #(.Depth(PAGES), .IdxBits(IW)) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wlen_i  (l_wlen),
    .wprv_i  (l_wprv),
    .wnxt_i  (l_wnxt),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rlen_o  (l_rlen),
    .rprv_o  (l_rprv),
    .rnxt_o  (l_rnxt)
  );

  // Address arithmetic shared by the sequencer
  logic [31:0]   pg_first, pg_last;
  logic          fr_bad, head_in, nh_ok, nf_ok;
  logic [IW-1:0] nh, rb_len, fa_len, fa_cnt, fb_cnt, fd_cnt;
  logic [IW:0]   nf, al_last, al_pos;

  assign pg_first = a_q >> PAGE_SHIFT;
  assign pg_last  = (e_q - 32'd1) >> PAGE_SHIFT;
  assign fr_bad   = ((a_q & OffMask) != 32'd0) || (pg_first >= PagesW);
  assign head_in  = (idx_q != LastIdx);
  assign nh_ok    = (lenf_q <= idx_q);
  assign nh       = idx_q - lenf_q;
  assign nf       = {1'b0, idx_q} + {1'b0, lenh_q};
  assign nf_ok    = (nf < PagesX);
  assign rb_len   = i_q - start_q;
  assign al_last  = {1'b0, head_q} + {1'b0, l_rlen} - (IW+1)'(1);
  assign al_pos   = ext_q - (IW+1)'(1);
  assign fa_len   = nh_ok ? l_rlen : '0;
  assign fa_cnt   = sat_len({1'b0, fa_len} + (IW+1)'(1));
  assign fb_cnt   = sat_len({1'b0, lenh_q} + (IW+1)'(1));
  assign fd_cnt   = sat_len({1'b0, lenf_q} + {1'b0, lenh_q} + (IW+1)'(1));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    op_d       = op_q;
    a_d        = a_q;
    e_d        = e_q;
    type_d     = type_q;
    flags_d    = flags_q;
    refs_d     = refs_q;
    idx_d      = idx_q;
    i_d        = i_q;
    mlast_d    = mlast_q;
    start_d    = start_q;
    head_d     = head_q;
    lenf_d     = lenf_q;
    lenh_d     = lenh_q;
    nxt_d      = nxt_q;
    prv_d      = prv_q;
    cnt_d      = cnt_q;
    ext_d      = ext_q;
    in_run_d   = in_run_q;
    has_foot_d = has_foot_q;
    has_head_d = has_head_q;
    status_d   = status_q;
    addr_d     = addr_q;
    rel_d      = rel_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    d_we    = 1'b0;
    d_waddr = idx_q[AW-1:0];
    d_wdata = '{ptype: type_q, flags: flags_q, refs: refs_q};
    d_re    = 1'b0;
    d_raddr = idx_q[AW-1:0];
    l_we    = '0;
    l_waddr = idx_q[AW-1:0];
    l_wlen  = '0;
    l_wprv  = Nil;
    l_wnxt  = Nil;
    l_re    = 1'b0;
    l_raddr = idx_q[AW-1:0];

    // Drain the result register
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      // Sweep both stores to their cleared contents after reset
      S_CLR: begin
        d_we    = 1'b1;
        d_waddr = clr_q;
        d_wdata = '0;
        l_we    = '{len: 1'b1, prv: 1'b1, nxt: 1'b1};
        l_waddr = clr_q;
        if (clr_q == LastAdr) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = op_e'(s_axis_tuser_i);
          a_d      = s_axis_tdata_i[31:0];
          e_d      = s_axis_tdata_i[63:32];
          type_d   = s_axis_tdata_i[67:64];
          flags_d  = s_axis_tdata_i[83:68];
          refs_d   = s_axis_tdata_i[99:84];
          status_d = ST_OK;
          addr_d   = '0;
          rel_d    = 1'b0;
          unique case (op_e'(s_axis_tuser_i))
            OP_MARK:    state_d = S_MK0;
            OP_REBUILD: begin
              head_d   = Nil;
              i_d      = '0;
              in_run_d = 1'b0;
              state_d  = S_RB_RD;
            end
            OP_ALLOC:   state_d = S_AL0;
            OP_FREE:    state_d = S_FR0;
            default:    state_d = S_IDLE;
          endcase
        end
      end

      // Mark: check and clip the range, then stamp one page per cycle
      S_MK0: begin
        if (e_q <= a_q) begin
          status_d = ST_EMPTY_RANGE;
          state_d  = S_DONE;
        end else if (pg_first >= PagesW) begin
          status_d = ST_BAD_ADDR;
          state_d  = S_DONE;
        end else begin
          i_d     = pg_first[IW-1:0];
          mlast_d = (pg_last >= PagesW) ? LastIdx : pg_last[IW-1:0];
          state_d = S_MKW;
        end
      end
      S_MKW: begin
        d_we    = 1'b1;
        d_waddr = i_q[AW-1:0];
        if (i_q == mlast_q) begin
          state_d = S_DONE;
        end else begin
          i_d = i_q + IW'(1);
        end
      end

      // Rebuild: read each type, then close a run with its tags and list push
      S_RB_RD: begin
        d_re    = 1'b1;
        d_raddr = i_q[AW-1:0];
        state_d = S_RB_CHK;
      end
      S_RB_CHK: begin
        if (d_rdata.ptype != 4'd0) begin
          if (in_run_q) begin
            state_d = S_RB_E1;
          end else begin
            l_we    = '{len: 1'b1, prv: 1'b1, nxt: 1'b1};
            l_waddr = i_q[AW-1:0];
            i_d     = i_q + IW'(1);
            state_d = (i_q == LastIdx) ? S_DONE : S_RB_RD;
          end
        end else begin
          start_d  = in_run_q ? start_q : i_q;
          in_run_d = 1'b1;
          l_we     = '{len: 1'b1, prv: 1'b1, nxt: 1'b0};
          l_waddr  = i_q[AW-1:0];
          l_wprv   = in_run_q ? start_q : i_q;
          i_d      = i_q + IW'(1);
          state_d  = (i_q == LastIdx) ? S_RB_E1 : S_RB_RD;
        end
      end
      S_RB_E1: begin
        l_we    = '{len: 1'b1, prv: 1'b1, nxt: 1'b1};
        l_waddr = start_q[AW-1:0];
        l_wlen  = rb_len;
        l_wnxt  = head_q;
        state_d = S_RB_E2;
      end
      S_RB_E2: begin
        l_we.len = 1'b1;
        l_waddr  = AW'(i_q - IW'(1));
        l_wlen   = rb_len;
        state_d  = S_RB_E3;
      end
      S_RB_E3: begin
        if (head_q != Nil) begin
          l_we.prv = 1'b1;
          l_waddr  = head_q[AW-1:0];
          l_wprv   = start_q;
        end
        head_d   = start_q;
        in_run_d = 1'b0;
        state_d  = (i_q == Nil) ? S_DONE : S_RB_RD;
      end

      // Alloc: read the head run, take its last page or unlink it
      S_AL0: begin
        if (head_q == Nil) begin
          status_d = ST_NONE_FREE;
          state_d  = S_DONE;
        end else if (type_q == 4'd0) begin
          status_d = ST_UNUSED_TYPE;
          state_d  = S_DONE;
        end else begin
          l_re    = 1'b1;
          l_raddr = head_q[AW-1:0];
          state_d = S_AL1;
        end
      end
      S_AL1: begin
        d_wdata = '{ptype: type_q, flags: flags_q, refs: 16'd1};
        if (l_rlen > IW'(1)) begin
          d_we     = (al_last < PagesX);
          d_waddr  = al_last[AW-1:0];
          l_we.len = 1'b1;
          l_waddr  = head_q[AW-1:0];
          l_wlen   = l_rlen - IW'(1);
          cnt_d    = l_rlen - IW'(1);
          ext_d    = al_last;
          addr_d   = 32'(al_last) << PAGE_SHIFT;
          state_d  = S_AL2;
        end else begin
          d_we    = 1'b1;
          d_waddr = head_q[AW-1:0];
          addr_d  = 32'(head_q) << PAGE_SHIFT;
          head_d  = l_rnxt;
          nxt_d   = l_rnxt;
          state_d = (l_rnxt != Nil) ? S_AL3 : S_DONE;
        end
      end
      S_AL2: begin
        l_we.len = (al_pos < PagesX);
        l_waddr  = al_pos[AW-1:0];
        l_wlen   = cnt_q;
        state_d  = S_DONE;
      end
      S_AL3: begin
        l_we.prv = 1'b1;
        l_waddr  = nxt_q[AW-1:0];
        l_wprv   = Nil;
        state_d  = S_DONE;
      end

      // Free: check, drop a reference, then gather neighbor tags
      S_FR0: begin
        if (fr_bad) begin
          status_d = ST_BAD_ADDR;
          state_d  = S_DONE;
        end else begin
          idx_d   = pg_first[IW-1:0];
          d_re    = 1'b1;
          d_raddr = pg_first[AW-1:0];
          state_d = S_FR1;
        end
      end
      S_FR1: begin
        if (d_rdata.ptype == 4'd0) begin
          status_d = ST_ALREADY_FREE;
          state_d  = S_DONE;
        end else if (d_rdata.refs == 16'd0) begin
          status_d = ST_ZERO_REFS;
          state_d  = S_DONE;
        end else if (d_rdata.refs != 16'd1) begin
          d_we    = 1'b1;
          d_wdata = '{ptype: d_rdata.ptype, flags: d_rdata.flags,
                      refs: d_rdata.refs - 16'd1};
          state_d = S_DONE;
        end else begin
          d_we    = 1'b1;
          d_wdata = '{ptype: 4'd0, flags: d_rdata.flags, refs: 16'd0};
          rel_d   = 1'b1;
          d_re    = (idx_q != '0);
          d_raddr = AW'(idx_q - IW'(1));
          state_d = S_FR2;
        end
      end
      S_FR2: begin
        has_foot_d = (idx_q != '0) && (d_rdata.ptype == 4'd0);
        d_re       = head_in;
        d_raddr    = AW'(idx_q + IW'(1));
        l_re       = (idx_q != '0);
        l_raddr    = AW'(idx_q - IW'(1));
        state_d    = S_FR3;
      end
      S_FR3: begin
        has_head_d = head_in && (d_rdata.ptype == 4'd0);
        lenf_d     = (idx_q != '0) ? l_rlen : '0;
        l_re       = head_in;
        l_raddr    = AW'(idx_q + IW'(1));
        state_d    = S_FR4;
      end
      S_FR4: begin
        lenh_d = head_in ? l_rlen : '0;
        nxt_d  = head_in ? l_rnxt : Nil;
        prv_d  = head_in ? l_rprv : Nil;
        priority if (has_foot_q && !has_head_q) begin
          l_re    = nh_ok;
          l_raddr = nh[AW-1:0];
          state_d = S_FA1;
        end else if (!has_foot_q && has_head_q) begin
          state_d = S_FB1;
        end else if (!has_foot_q && !has_head_q) begin
          state_d = S_FC1;
        end else begin
          state_d = S_FD1;
        end
      end

      // Merge with the run below
      S_FA1: begin
        cnt_d    = fa_cnt;
        l_we.len = nh_ok;
        l_waddr  = nh[AW-1:0];
        l_wlen   = fa_cnt;
        state_d  = S_FA2;
      end
      S_FA2: begin
        l_we    = '{len: 1'b1, prv: 1'b1, nxt: 1'b1};
        l_wlen  = cnt_q;
        state_d = S_DONE;
      end

      // Merge with the run above, taking over its list place
      S_FB1: begin
        cnt_d    = fb_cnt;
        l_we.len = nf_ok;
        l_waddr  = nf[AW-1:0];
        l_wlen   = fb_cnt;
        state_d  = S_FB2;
      end
      S_FB2: begin
        l_we    = '{len: 1'b1, prv: 1'b1, nxt: 1'b1};
        l_wlen  = cnt_q;
        l_wprv  = prv_q;
        l_wnxt  = nxt_q;
        state_d = S_FB3;
      end
      S_FB3: begin
        l_we.prv = (nxt_q != Nil);
        l_waddr  = nxt_q[AW-1:0];
        l_wprv   = idx_q;
        state_d  = S_FB4;
      end
      S_FB4: begin
        if (prv_q != Nil) begin
          l_we.nxt = 1'b1;
          l_waddr  = prv_q[AW-1:0];
          l_wnxt   = idx_q;
        end else begin
          head_d = idx_q;
        end
        state_d = S_DONE;
      end

      // Lone page: push a one-page run at the list head
      S_FC1: begin
        l_we    = '{len: 1'b1, prv: 1'b1, nxt: 1'b1};
        l_wlen  = IW'(1);
        l_wnxt  = head_q;
        state_d = S_FC2;
      end
      S_FC2: begin
        l_we.prv = (head_q != Nil);
        l_waddr  = head_q[AW-1:0];
        l_wprv   = idx_q;
        head_d   = idx_q;
        state_d  = S_DONE;
      end

      // Join both neighbors, unlink the run above
      S_FD1: begin
        cnt_d    = fd_cnt;
        l_we.len = nh_ok;
        l_waddr  = nh[AW-1:0];
        l_wlen   = fd_cnt;
        state_d  = S_FD2;
      end
      S_FD2: begin
        l_we.len = nf_ok;
        l_waddr  = nf[AW-1:0];
        l_wlen   = cnt_q;
        state_d  = S_FD3;
      end
      S_FD3: begin
        if (prv_q != Nil) begin
          l_we.nxt = 1'b1;
          l_waddr  = prv_q[AW-1:0];
          l_wnxt   = nxt_q;
        end else begin
          head_d = nxt_q;
        end
        state_d = S_FD4;
      end
      S_FD4: begin
        l_we.prv = (nxt_q != Nil);
        l_waddr  = nxt_q[AW-1:0];
        l_wprv   = prv_q;
        state_d  = S_DONE;
      end

      // Post the result once the output register is free
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'd0, rel_q, addr_q, status_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      op_q       <= OP_MARK;
      a_q        <= '0;
      e_q        <= '0;
      type_q     <= '0;
      flags_q    <= '0;
      refs_q     <= '0;
      idx_q      <= '0;
      i_q        <= '0;
      mlast_q    <= '0;
      start_q    <= '0;
      head_q     <= Nil;
      lenf_q     <= '0;
      lenh_q     <= '0;
      nxt_q      <= Nil;
      prv_q      <= Nil;
      cnt_q      <= '0;
      ext_q      <= '0;
      in_run_q   <= 1'b0;
      has_foot_q <= 1'b0;
      has_head_q <= 1'b0;
      status_q   <= ST_OK;
      addr_q     <= '0;
      rel_q      <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      op_q       <= op_d;
      a_q        <= a_d;
      e_q        <= e_d;
      type_q     <= type_d;
      flags_q    <= flags_d;
      refs_q     <= refs_d;
      idx_q      <= idx_d;
      i_q        <= i_d;
      mlast_q    <= mlast_d;
      start_q    <= start_d;
      head_q     <= head_d;
      lenf_q     <= lenf_d;
      lenh_q     <= lenh_d;
      nxt_q      <= nxt_d;
      prv_q      <= prv_d;
      cnt_q      <= cnt_d;
      ext_q      <= ext_d;
      in_run_q   <= in_run_d;
      has_foot_q <= has_foot_d;
      has_head_q <= has_head_d;
      status_q   <= status_d;
      addr_q     <= addr_d;
      rel_q      <= rel_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

// ----- design/pfra_checker.sv -----
`default_nettype none

`include "page_frame_run_allocator_macros.svh"

module pfra_checker
  import pfra_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [InDataW-1:0]  s_axis_tdata_i,
  input wire logic [1:0]          s_axis_tuser_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  // Hold a stalled result
  `PFRA_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")

  // Go busy right after taking an item
  `PFRA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready stayed high after accept")

  // A released page reports ok and no address
  `PFRA_ASSERT_IMP(a_release_ok, m_axis_tvalid_o && m_axis_tdata_o[35], (m_axis_tdata_o[2:0] == ST_OK) && (m_axis_tdata_o[34:3] == 32'd0), "release with bad status or address")

  // A nonzero address only comes from a successful alloc
  `PFRA_ASSERT_IMP(a_addr_ok, m_axis_tvalid_o && (m_axis_tdata_o[34:3] != 32'd0), (m_axis_tdata_o[2:0] == ST_OK) && !m_axis_tdata_o[35], "address with failed status")

endmodule

bind page_frame_run_allocator pfra_checker u_pfra_checker (.*);

`default_nettype wire
